### hdl/tsched_pkg.sv
// Shared constants, types and helpers for the thread scheduler.
`default_nettype none
package tsched_pkg;

  // Ring, event and semaphore sizes
  localparam int NUM_THREADS = 6;
  localparam int NUM_EVENTS  = 2;
  localparam int NUM_SEMS    = 8;

  // Field widths
  localparam int THREAD_W = 3;
  localparam int SEM_W    = 3;
  localparam int CMD_W    = 3;
  localparam int SLEEP_W  = 31;
  localparam int CNT_W    = 16;
  localparam int PERIOD_W = 16;
  localparam int ADD_W    = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SLICE_END = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TICK      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SLEEP     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WAIT      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SIGNAL    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_INIT      = 3'd5;

  // Event periods handed from the register file to the core
  typedef logic [NUM_EVENTS-1:0][PERIOD_W-1:0] period_arr_t;

  // Status fields of one result item
  typedef struct packed {
    logic                    switched;
    logic                    none_ready;
    logic                    blocked_now;
    logic                    woke_valid;
    logic [THREAD_W-1:0]     woke_thread;
    logic [NUM_EVENTS-1:0]   event_fire;
    logic signed [CNT_W-1:0] sem_count;
  } result_t;

  // Next thread around the ring
  function automatic logic [THREAD_W-1:0] next_thread(input logic [THREAD_W-1:0] t);
    logic [THREAD_W-1:0] n;
    n = (t == THREAD_W'(NUM_THREADS - 1)) ? '0 : t + 1'b1;
    return n;
  endfunction

endpackage
`default_nettype wire

### hdl/tsched_cfg.sv
// APB register file holding the periodic event periods.
`default_nettype none
module tsched_cfg (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output tsched_pkg::period_arr_t    periods_o
);

  tsched_pkg::period_arr_t period_q;
  logic                    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Write the addressed period, reset to one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < tsched_pkg::NUM_EVENTS; e++) begin
        period_q[e] <= tsched_pkg::PERIOD_W'(1);
      end
    end else if (wr_en) begin
      period_q[paddr[2]] <= pwdata[tsched_pkg::PERIOD_W-1:0];
    end
  end

  // Return the addressed period
  always_comb begin
    prdata = {{(32 - tsched_pkg::PERIOD_W){1'b0}}, period_q[paddr[2]]};
  end

  assign periods_o = period_q;

endmodule
`default_nettype wire

### hdl/tsched_core.sv
// Command sequencer with thread table, semaphores and one shared adder.
`default_nettype none
module tsched_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic [tsched_pkg::CMD_W-1:0]          command_i,
  input  wire logic [tsched_pkg::SEM_W-1:0]          sem_id_i,
  input  wire logic [tsched_pkg::SLEEP_W-1:0]        sleep_ms_i,
  input  wire logic signed [tsched_pkg::CNT_W-1:0]   init_value_i,
  input  wire tsched_pkg::period_arr_t               periods_i,
  output logic                                       busy_o,
  output logic                                       done_o,
  output logic [tsched_pkg::THREAD_W-1:0]            running_thread_o,
  output tsched_pkg::result_t                        result_o
);

  localparam int NT = tsched_pkg::NUM_THREADS;
  localparam int NE = tsched_pkg::NUM_EVENTS;
  localparam int NS = tsched_pkg::NUM_SEMS;
  localparam int TW = tsched_pkg::THREAD_W;
  localparam int PW = tsched_pkg::PERIOD_W;
  localparam int CW = tsched_pkg::CNT_W;
  localparam int AW = tsched_pkg::ADD_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_TICK = 3'd2;
  localparam logic [2:0] ST_WALK = 3'd3;
  localparam logic [2:0] ST_WAKE = 3'd4;

  logic [2:0]                      state_q;
  logic [tsched_pkg::CMD_W-1:0]    cmd_q;
  logic [tsched_pkg::SEM_W-1:0]    sem_q;
  logic [tsched_pkg::SLEEP_W-1:0]  ms_q;
  logic signed [CW-1:0]            init_q;
  logic [TW-1:0]                   cur_q;
  logic [TW-1:0]                   ptr_q;
  logic [TW-1:0]                   step_q;
  logic [tsched_pkg::SLEEP_W-1:0]  sleep_q [NT];
  logic [NT-1:0]                   blk_q;
  logic [tsched_pkg::SEM_W-1:0]    blk_on_q [NT];
  logic signed [CW-1:0]            sem_cnt_q [NS];
  logic [PW-1:0]                   phase_q [NE];
  tsched_pkg::result_t             res_q;
  logic                            done_q;

  logic [AW-1:0]                   add_a;
  logic [AW-1:0]                   add_b;
  logic [AW-1:0]                   sum;
  logic signed [CW-1:0]            cnt_cur;
  logic signed [CW-1:0]            cnt_new;
  logic                            sem_ok;
  logic                            eligible;
  logic                            wake_hit;
  logic                            last_step;
  logic [TW-1:0]                   ptr_next;
  logic [TW-1:0]                   walk_first;
  logic [PW-1:0]                   ph_new [NE];
  logic [NE-1:0]                   fire;

  // Decode the addressed semaphore and the current walk position
  assign sem_ok     = (32'(sem_q) < NS);
  assign cnt_cur    = sem_cnt_q[sem_q];
  assign eligible   = (sleep_q[ptr_q] == '0) && !blk_q[ptr_q];
  assign wake_hit   = blk_q[ptr_q] && (blk_on_q[ptr_q] == sem_q);
  assign last_step  = (step_q == TW'(NT - 1));
  assign ptr_next   = tsched_pkg::next_thread(ptr_q);
  assign walk_first = tsched_pkg::next_thread(cur_q);

  // Shared adder: sleep decrement on a tick, count step otherwise
  always_comb begin
    if (state_q == ST_TICK) begin
      add_a = {1'b0, sleep_q[ptr_q]};
      add_b = '1;
    end else begin
      add_a = AW'(cnt_cur);
      add_b = (cmd_q == tsched_pkg::CMD_WAIT) ? '1 : AW'(1);
    end
    sum = add_a + add_b;
  end

  // Saturate the semaphore count at the signed limits
  always_comb begin
    if ((cmd_q == tsched_pkg::CMD_WAIT && cnt_cur == {1'b1, {(CW-1){1'b0}}}) ||
        (cmd_q == tsched_pkg::CMD_SIGNAL && cnt_cur == {1'b0, {(CW-1){1'b1}}})) begin
      cnt_new = cnt_cur;
    end else begin
      cnt_new = sum[CW-1:0];
    end
  end

  // Advance each event phase, wrap at its period
  always_comb begin
    for (int e = 0; e < NE; e++) begin
      logic [PW-1:0] per;
      logic [PW:0]   ph_inc;
      per      = (periods_i[e] == '0) ? PW'(1) : periods_i[e];
      ph_inc   = {1'b0, phase_q[e]} + 1'b1;
      ph_new[e] = (ph_inc >= {1'b0, per}) ? '0 : ph_inc[PW-1:0];
      fire[e]  = (ph_new[e] == PW'(e));
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cmd_q   <= '0;
      sem_q   <= '0;
      ms_q    <= '0;
      init_q  <= '0;
      cur_q   <= '0;
      ptr_q   <= '0;
      step_q  <= '0;
      blk_q   <= '0;
      res_q   <= '0;
      done_q  <= 1'b0;
      for (int t = 0; t < NT; t++) begin
        sleep_q[t]  <= '0;
        blk_on_q[t] <= '0;
      end
      for (int s = 0; s < NS; s++) begin
        sem_cnt_q[s] <= '0;
      end
      for (int e = 0; e < NE; e++) begin
        phase_q[e] <= '0;
      end
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            cmd_q   <= command_i;
            sem_q   <= sem_id_i;
            ms_q    <= sleep_ms_i;
            init_q  <= init_value_i;
            res_q   <= '0;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          unique case (cmd_q)
            tsched_pkg::CMD_SLICE_END: begin
              ptr_q   <= walk_first;
              step_q  <= '0;
              state_q <= ST_WALK;
            end
            tsched_pkg::CMD_TICK: begin
              for (int e = 0; e < NE; e++) begin
                phase_q[e] <= ph_new[e];
              end
              res_q.event_fire <= fire;
              ptr_q   <= '0;
              state_q <= ST_TICK;
            end
            tsched_pkg::CMD_SLEEP: begin
              sleep_q[cur_q] <= ms_q;
              ptr_q   <= walk_first;
              step_q  <= '0;
              state_q <= ST_WALK;
            end
            tsched_pkg::CMD_WAIT: begin
              if (sem_ok) begin
                sem_cnt_q[sem_q] <= cnt_new;
                res_q.sem_count  <= cnt_new;
                if (cnt_new[CW-1]) begin
                  blk_q[cur_q]      <= 1'b1;
                  blk_on_q[cur_q]   <= sem_q;
                  res_q.blocked_now <= 1'b1;
                  ptr_q   <= walk_first;
                  step_q  <= '0;
                  state_q <= ST_WALK;
                end else begin
                  state_q <= ST_IDLE;
                  done_q  <= 1'b1;
                end
              end else begin
                state_q <= ST_IDLE;
                done_q  <= 1'b1;
              end
            end
            tsched_pkg::CMD_SIGNAL: begin
              if (sem_ok) begin
                sem_cnt_q[sem_q] <= cnt_new;
                res_q.sem_count  <= cnt_new;
                if (cnt_new[CW-1] || cnt_new == '0) begin
                  ptr_q   <= walk_first;
                  step_q  <= '0;
                  state_q <= ST_WAKE;
                end else begin
                  state_q <= ST_IDLE;
                  done_q  <= 1'b1;
                end
              end else begin
                state_q <= ST_IDLE;
                done_q  <= 1'b1;
              end
            end
            tsched_pkg::CMD_INIT: begin
              if (sem_ok) begin
                sem_cnt_q[sem_q] <= init_q;
                res_q.sem_count  <= init_q;
              end
              state_q <= ST_IDLE;
              done_q  <= 1'b1;
            end
            default: begin
              state_q <= ST_IDLE;
              done_q  <= 1'b1;
            end
          endcase
        end
        ST_TICK: begin
          // Decrement one sleep counter per cycle
          if (sleep_q[ptr_q] != '0) begin
            sleep_q[ptr_q] <= sum[tsched_pkg::SLEEP_W-1:0];
          end
          if (ptr_q == TW'(NT - 1)) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
        ST_WALK: begin
          // Check one ring entry per cycle, running thread last
          if (eligible) begin
            cur_q          <= ptr_q;
            res_q.switched <= (ptr_q != cur_q);
            state_q        <= ST_IDLE;
            done_q         <= 1'b1;
          end else if (last_step) begin
            res_q.none_ready <= 1'b1;
            state_q          <= ST_IDLE;
            done_q           <= 1'b1;
          end else begin
            ptr_q  <= ptr_next;
            step_q <= step_q + 1'b1;
          end
        end
        ST_WAKE: begin
          // Release the first thread blocked on this semaphore
          if (wake_hit) begin
            blk_q[ptr_q]      <= 1'b0;
            res_q.woke_valid  <= 1'b1;
            res_q.woke_thread <= ptr_q;
            state_q           <= ST_IDLE;
            done_q            <= 1'b1;
          end else if (last_step) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end else begin
            ptr_q  <= ptr_next;
            step_q <= step_q + 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign running_thread_o = cur_q;
  assign result_o         = res_q;

endmodule
`default_nettype wire

### hdl/thread_scheduler_with_semaphores.sv
// Round-robin scheduler for six threads with semaphores and periodic events.
// Init, a wait that does not block, a signal that leaves the count positive and unused
// codes finish in the execute state; slice end, sleep, a blocking wait and a waking signal
// then walk the ring, one ring entry checked per cycle; a tick steps every sleep counter.
// The next item is accepted while done_o is high; none is taken while busy is high.
// The receiver cannot stall. Reset clears thread, semaphore and phase state; periods go to 1.
`default_nettype none
module thread_scheduler_with_semaphores (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  output logic                                       busy,
  output logic                                       done_o,
  input  wire logic [tsched_pkg::CMD_W-1:0]          command_i,
  input  wire logic [tsched_pkg::SEM_W-1:0]          sem_id_i,
  input  wire logic [tsched_pkg::SLEEP_W-1:0]        sleep_ms_i,
  input  wire logic signed [tsched_pkg::CNT_W-1:0]   init_value_i,
  output logic [tsched_pkg::THREAD_W-1:0]            running_thread_o,
  output logic                                       switched_o,
  output logic                                       none_ready_o,
  output logic                                       blocked_now_o,
  output logic                                       woke_valid_o,
  output logic [tsched_pkg::THREAD_W-1:0]            woke_thread_o,
  output logic                                       event0_fire_o,
  output logic                                       event1_fire_o,
  output logic signed [tsched_pkg::CNT_W-1:0]        sem_count_o,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [2:0]                            paddr,
  input  wire logic [31:0]                           pwdata,
  output logic [31:0]                                prdata,
  output logic                                       pready
);

  tsched_pkg::period_arr_t periods;
  tsched_pkg::result_t     result;

  tsched_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .periods_o (periods)
  );

  tsched_core u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .command_i        (command_i),
    .sem_id_i         (sem_id_i),
    .sleep_ms_i       (sleep_ms_i),
    .init_value_i     (init_value_i),
    .periods_i        (periods),
    .busy_o           (busy),
    .done_o           (done_o),
    .running_thread_o (running_thread_o),
    .result_o         (result)
  );

  // Unpack the result fields
  assign switched_o    = result.switched;
  assign none_ready_o  = result.none_ready;
  assign blocked_now_o = result.blocked_now;
  assign woke_valid_o  = result.woke_valid;
  assign woke_thread_o = result.woke_thread;
  assign event0_fire_o = result.event_fire[0];
  assign event1_fire_o = result.event_fire[1];
  assign sem_count_o   = result.sem_count;

endmodule
`default_nettype wire

### verif/thread_scheduler_with_semaphores_test.sv
// Self-checking testbench for the round-robin thread scheduler with semaphores.
`timescale 1ns / 1ps
module thread_scheduler_with_semaphores_test;

  // Sizes, widths and codes taken from the shared package
  localparam int NUM_THREADS = tsched_pkg::NUM_THREADS;
  localparam int NUM_EVENTS  = tsched_pkg::NUM_EVENTS;
  localparam int NUM_SEMS    = tsched_pkg::NUM_SEMS;
  localparam int THREAD_W    = tsched_pkg::THREAD_W;
  localparam int SEM_W       = tsched_pkg::SEM_W;
  localparam int CMD_W       = tsched_pkg::CMD_W;
  localparam int SLEEP_W     = tsched_pkg::SLEEP_W;
  localparam int CNT_W       = tsched_pkg::CNT_W;
  localparam int PERIOD_W    = tsched_pkg::PERIOD_W;
  localparam logic [CMD_W-1:0] CMD_SLICE_END = tsched_pkg::CMD_SLICE_END;
  localparam logic [CMD_W-1:0] CMD_TICK      = tsched_pkg::CMD_TICK;
  localparam logic [CMD_W-1:0] CMD_SLEEP     = tsched_pkg::CMD_SLEEP;
  localparam logic [CMD_W-1:0] CMD_WAIT      = tsched_pkg::CMD_WAIT;
  localparam logic [CMD_W-1:0] CMD_SIGNAL    = tsched_pkg::CMD_SIGNAL;
  localparam logic [CMD_W-1:0] CMD_INIT      = tsched_pkg::CMD_INIT;

  // Codes the block treats as no-ops
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  // Register byte addresses
  localparam logic [2:0] ADDR_PERIOD0 = 3'd0;
  localparam logic [2:0] ADDR_PERIOD1 = 3'd4;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 12;

  // One scheduler outcome as seen on the result ports
  typedef struct {
    logic [THREAD_W-1:0]     running;
    logic                    switched;
    logic                    none_ready;
    logic                    blocked_now;
    logic                    woke_valid;
    logic [THREAD_W-1:0]     woke_thr;
    logic                    fire0;
    logic                    fire1;
    logic signed [CNT_W-1:0] cnt;
  } outcome_t;

  // Scheduler state mirror plus the queue of outcomes still due
  class sched_checker;
    int              cur;
    int unsigned     sleep_left[NUM_THREADS];
    bit              held[NUM_THREADS];
    int              held_on[NUM_THREADS];
    int              sem_val[NUM_SEMS];
    int              phase[NUM_EVENTS];
    int              period[NUM_EVENTS];
    outcome_t        due[$];
    int              errors;

    function new();
      cur = 0;
      errors = 0;
      foreach (sleep_left[i]) begin
        sleep_left[i] = 0;
        held[i] = 0;
        held_on[i] = 0;
      end
      foreach (sem_val[i]) sem_val[i] = 0;
      foreach (phase[i]) begin
        phase[i] = 0;
        period[i] = 1;
      end
    endfunction

    function void set_period(int idx, logic [31:0] value);
      period[idx] = int'(value[PERIOD_W-1:0]);
    endfunction

    function int pending();
      return due.size();
    endfunction

    // Advance to the first eligible thread after the running one
    function void walk(inout outcome_t o);
      int t;
      for (int k = 1; k <= NUM_THREADS; k++) begin
        t = (cur + k) % NUM_THREADS;
        if (sleep_left[t] == 0 && !held[t]) begin
          o.switched = (t != cur);
          cur = t;
          return;
        end
      end
      o.none_ready = 1'b1;
    endfunction

    // Predict the outcome of one accepted command
    function void note_command(logic [CMD_W-1:0] cmd, logic [SEM_W-1:0] sem,
                               logic [SLEEP_W-1:0] ms, logic signed [CNT_W-1:0] iv);
      outcome_t o;
      int       ph;
      int       p;
      int       t;
      o = '{default: '0};
      case (cmd)
        CMD_SLICE_END: walk(o);
        CMD_TICK: begin
          for (int i = 0; i < NUM_EVENTS; i++) begin
            p = (period[i] == 0) ? 1 : period[i];
            ph = phase[i] + 1;
            if (ph >= p) ph = 0;
            phase[i] = ph;
            if (ph == i) begin
              if (i == 0) o.fire0 = 1'b1;
              else o.fire1 = 1'b1;
            end
          end
          foreach (sleep_left[i]) if (sleep_left[i] != 0) sleep_left[i]--;
        end
        CMD_SLEEP: begin
          sleep_left[cur] = int'(ms);
          walk(o);
        end
        CMD_WAIT: begin
          if (sem_val[sem] > -32768) sem_val[sem]--;
          o.cnt = CNT_W'(sem_val[sem]);
          if (sem_val[sem] < 0) begin
            held[cur] = 1'b1;
            held_on[cur] = int'(sem);
            o.blocked_now = 1'b1;
            walk(o);
          end
        end
        CMD_SIGNAL: begin
          if (sem_val[sem] < 32767) sem_val[sem]++;
          o.cnt = CNT_W'(sem_val[sem]);
          if (sem_val[sem] <= 0) begin
            for (int k = 1; k <= NUM_THREADS; k++) begin
              t = (cur + k) % NUM_THREADS;
              if (held[t] && held_on[t] == int'(sem)) begin
                held[t] = 1'b0;
                o.woke_valid = 1'b1;
                o.woke_thr = THREAD_W'(t);
                break;
              end
            end
          end
        end
        CMD_INIT: begin
          sem_val[sem] = int'(iv);
          o.cnt = iv;
        end
        default: ;
      endcase
      o.running = THREAD_W'(cur);
      due.push_back(o);
    endfunction

    task report(string what, int got, int want);
      $display("ERROR: %s got %0d want %0d", what, got, want);
      errors++;
    endtask

    // Compare one result against the oldest outcome due
    task check_result(outcome_t got);
      outcome_t want;
      if (due.size() == 0) begin
        report("result with nothing pending, running_thread", got.running, -1);
        return;
      end
      want = due.pop_front();
      if (got.running !== want.running)
        report("running_thread", got.running, want.running);
      if (got.switched !== want.switched)
        report("switched", got.switched, want.switched);
      if (got.none_ready !== want.none_ready)
        report("none_ready", got.none_ready, want.none_ready);
      if (got.blocked_now !== want.blocked_now)
        report("blocked_now", got.blocked_now, want.blocked_now);
      if (got.woke_valid !== want.woke_valid)
        report("woke_valid", got.woke_valid, want.woke_valid);
      if (got.woke_thr !== want.woke_thr)
        report("woke_thread", got.woke_thr, want.woke_thr);
      if (got.fire0 !== want.fire0)
        report("event0_fire", got.fire0, want.fire0);
      if (got.fire1 !== want.fire1)
        report("event1_fire", got.fire1, want.fire1);
      if (got.cnt !== want.cnt)
        report("sem_count", int'(got.cnt), int'(want.cnt));
    endtask
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    done_o;
  logic [CMD_W-1:0]        command_i;
  logic [SEM_W-1:0]        sem_id_i;
  logic [SLEEP_W-1:0]      sleep_ms_i;
  logic signed [CNT_W-1:0] init_value_i;
  logic [THREAD_W-1:0]     running_thread_o;
  logic                    switched_o;
  logic                    none_ready_o;
  logic                    blocked_now_o;
  logic                    woke_valid_o;
  logic [THREAD_W-1:0]     woke_thread_o;
  logic                    event0_fire_o;
  logic                    event1_fire_o;
  logic signed [CNT_W-1:0] sem_count_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [2:0]              paddr;
  logic [31:0]             pwdata;
  logic [31:0]             prdata;
  logic                    pready;

  sched_checker sb;
  int           cycles = 0;

  thread_scheduler_with_semaphores u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .done_o           (done_o),
    .command_i        (command_i),
    .sem_id_i         (sem_id_i),
    .sleep_ms_i       (sleep_ms_i),
    .init_value_i     (init_value_i),
    .running_thread_o (running_thread_o),
    .switched_o       (switched_o),
    .none_ready_o     (none_ready_o),
    .blocked_now_o    (blocked_now_o),
    .woke_valid_o     (woke_valid_o),
    .woke_thread_o    (woke_thread_o),
    .event0_fire_o    (event0_fire_o),
    .event1_fire_o    (event1_fire_o),
    .sem_count_o      (sem_count_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Clock generation
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Check each result item on its strobe
  always @(posedge clk_i) begin
    outcome_t got;
    if (rst_ni && done_o) begin
      got.running     = running_thread_o;
      got.switched    = switched_o;
      got.none_ready  = none_ready_o;
      got.blocked_now = blocked_now_o;
      got.woke_valid  = woke_valid_o;
      got.woke_thr    = woke_thread_o;
      got.fire0       = event0_fire_o;
      got.fire1       = event1_fire_o;
      got.cnt         = sem_count_o;
      sb.check_result(got);
    end
  end

  // Present one item and hold it until accepted
  task automatic send(logic [CMD_W-1:0] cmd, logic [SEM_W-1:0] sem,
                      logic [SLEEP_W-1:0] ms, logic signed [CNT_W-1:0] iv);
    start        <= 1'b1;
    command_i    <= cmd;
    sem_id_i     <= sem;
    sleep_ms_i   <= ms;
    init_value_i <= iv;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_command(cmd, sem, ms, iv);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Hold off until every due outcome has arrived
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Write a period register and read it back
  task automatic set_period(int idx, logic [31:0] value);
    logic [2:0] addr;
    addr = (idx == 0) ? ADDR_PERIOD0 : ADDR_PERIOD1;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.set_period(idx, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[PERIOD_W-1:0] !== value[PERIOD_W-1:0])
      sb.report("period readback", int'(prdata[PERIOD_W-1:0]), int'(value[PERIOD_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly well-formed scheduling traffic on a few semaphores
  task automatic random_item();
    int                      sel;
    logic [CMD_W-1:0]        cmd;
    logic [SEM_W-1:0]        sem;
    logic [SLEEP_W-1:0]      ms;
    logic signed [CNT_W-1:0] iv;
    sel = $urandom_range(99);
    sem = ($urandom_range(3) == 0) ? SEM_W'($urandom_range(7)) : SEM_W'($urandom_range(2));
    ms  = SLEEP_W'($urandom);
    iv  = CNT_W'($urandom);
    if (sel < 25) cmd = CMD_TICK;
    else if (sel < 40) cmd = CMD_SLICE_END;
    else if (sel < 50) begin
      cmd = CMD_SLEEP;
      ms = SLEEP_W'($urandom_range(8));
    end else if (sel < 70) cmd = CMD_WAIT;
    else if (sel < 90) cmd = CMD_SIGNAL;
    else if (sel < 96) begin
      cmd = CMD_INIT;
      if ($urandom_range(19) != 0) iv = CNT_W'($urandom_range(6)) - CNT_W'(3);
    end else cmd = ($urandom_range(1) == 1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
    send(cmd, sem, ms, iv);
  endtask

  // Send n items, idling while a draw stays under idle_pct of a hundred; drain halfway
  task automatic run_phase(int n, int idle_pct);
    for (int i = 0; i < n; i++) begin
      random_item();
      if (i == n / 2) drain();
      else while ($urandom_range(99) < idle_pct) pause(1);
    end
  endtask

  initial begin
    sb = new();
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    command_i    <= CMD_SLICE_END;
    sem_id_i     <= '0;
    sleep_ms_i   <= '0;
    init_value_i <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= ADDR_PERIOD0;
    pwdata       <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: event phases, zero period acting as one
    set_period(0, {16'hA5C3, 16'd5});
    set_period(1, 32'h0000_0000);
    send(CMD_SLICE_END, 3'd0, 31'd0, 16'sd0);
    repeat (4) send(CMD_TICK, 3'd0, 31'd0, 16'sd0);

    // Lowered period wraps the phase on the next tick
    drain();
    set_period(0, 32'd2);
    set_period(1, 32'd65535);
    send(CMD_TICK, 3'd0, 31'd0, 16'sd0);

    // Saturation at both count limits
    send(CMD_INIT, 3'd0, 31'd0, 16'sd32767);
    send(CMD_SIGNAL, 3'd0, 31'd0, 16'sd0);
    send(CMD_INIT, 3'd1, 31'd0, -16'sd32768);
    send(CMD_WAIT, 3'd1, 31'd0, 16'sd0);

    // Block then wake on one semaphore
    send(CMD_WAIT, 3'd3, 31'd0, 16'sd0);
    send(CMD_SIGNAL, 3'd3, 31'd0, 16'sd0);

    // Block all threads: single candidate, then nothing eligible
    repeat (4) send(CMD_WAIT, 3'd4, 31'd0, 16'sd0);
    send(CMD_SLICE_END, 3'd0, 31'd0, 16'sd0);
    send(CMD_WAIT, 3'd4, 31'd0, 16'sd0);
    repeat (5) send(CMD_SIGNAL, 3'd4, 31'd0, 16'sd0);
    send(CMD_SIGNAL, 3'd1, 31'd0, 16'sd0);
    send(CMD_SIGNAL, 3'd7, 31'd0, 16'sd0);
    send(CMD_SLEEP, 3'd0, 31'd0, 16'sd0);
    send(CMD_UNUSED_6, 3'd7, 31'h7FFF_FFFF, -16'sd1);
    send(CMD_UNUSED_7, 3'd5, 31'd0, 16'sd0);

    // Random phases with different sender gaps and periods
    drain();
    set_period(0, 32'd3);
    set_period(1, 32'd7);
    run_phase(180, 18);
    drain();
    set_period(0, 32'hFFFF_FFFF);
    set_period(1, 32'd1);
    run_phase(180, 84);
    drain();
    set_period(0, 32'd1);
    set_period(1, 32'd2);
    run_phase(180, 0);

    // Long sleeps last: they park threads for good
    send(CMD_SLEEP, 3'd0, 31'h7FFF_FFFF, 16'sd0);
    send(CMD_SLEEP, 3'd0, SLEEP_W'($urandom), 16'sd0);
    send(CMD_SLICE_END, 3'd0, 31'd0, 16'sd0);
    repeat (3) send(CMD_TICK, 3'd0, 31'd0, 16'sd0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
hdl/tsched_pkg.sv
hdl/tsched_cfg.sv
hdl/tsched_core.sv
hdl/thread_scheduler_with_semaphores.sv
verif/thread_scheduler_with_semaphores_test.sv
